### hdl/assert_macros.svh
// Assertion macros shared by the k-way merge selector RTL.
// No dependencies; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold in the same cycle as ante
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/kwm_pkg.sv
// Package for the k-way merge selector: types, codes and defaults.
// No dependencies; used by kwm_ctrl, kwm_dpath and kway_merge_min_heap.
package kwm_pkg;

  localparam int MAX_RUNS_DEF = 64;
  localparam int KEY_BITS_DEF = 32;
  localparam int RUN_IN_W     = 6;
  localparam int KEY_IN_W     = 32;
  localparam int LIVE_W       = 7;
  localparam int RUN_CODES    = 1 << RUN_IN_W;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_ADVANCE = 2'd1,
    CMD_EXHAUST = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_TAKE,
    OP_LOAD,
    OP_ADVANCE,
    OP_EX_DEC,
    OP_EX_KEY,
    OP_EX_SET,
    OP_UP_READ,
    OP_UP_KEY,
    OP_UP_MOVE,
    OP_DN_READ,
    OP_DN_KEY,
    OP_DN_MOVE,
    OP_FINISH,
    OP_EMIT
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_EX_KEY,
    ST_EX_SET,
    ST_UP_RD,
    ST_UP_KEY,
    ST_UP_CMP,
    ST_DN_RD,
    ST_DN_KEY,
    ST_DN_CMP,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    cmd_t cmd;
    logic err;
    logic last;
    logic at_root;
    logic up_go;
    logic dn_leaf;
    logic dn_go;
  } dp_status_t;

endpackage

### hdl/kwm_ctrl.sv
// Controller for the k-way merge selector: sequences load, advance and
// exhaust through the datapath. Depends on kwm_pkg.
module kwm_ctrl import kwm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t status,
  output logic       busy,
  output dp_op_t     op
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    busy       = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          op         = OP_TAKE;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status.err) begin
          state_next = ST_OUT;
        end else begin
          unique case (status.cmd)
            CMD_LOAD: begin
              op         = OP_LOAD;
              state_next = ST_UP_RD;
            end
            CMD_ADVANCE: begin
              op         = OP_ADVANCE;
              state_next = ST_DN_RD;
            end
            CMD_EXHAUST: begin
              op         = OP_EX_DEC;
              // last run leaving: heap empties, nothing to sift
              state_next = status.last ? ST_OUT : ST_EX_KEY;
            end
            CMD_NONE: begin
              state_next = ST_OUT;
            end
          endcase
        end
      end
      ST_EX_KEY: begin
        op         = OP_EX_KEY;
        state_next = ST_EX_SET;
      end
      ST_EX_SET: begin
        op         = OP_EX_SET;
        state_next = ST_DN_RD;
      end
      ST_UP_RD: begin
        if (status.at_root) begin
          state_next = ST_FIN;
        end else begin
          op         = OP_UP_READ;
          state_next = ST_UP_KEY;
        end
      end
      ST_UP_KEY: begin
        op         = OP_UP_KEY;
        state_next = ST_UP_CMP;
      end
      ST_UP_CMP: begin
        if (status.up_go) begin
          op         = OP_UP_MOVE;
          state_next = ST_UP_RD;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_DN_RD: begin
        if (status.dn_leaf) begin
          state_next = ST_FIN;
        end else begin
          op         = OP_DN_READ;
          state_next = ST_DN_KEY;
        end
      end
      ST_DN_KEY: begin
        op         = OP_DN_KEY;
        state_next = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        if (status.dn_go) begin
          op         = OP_DN_MOVE;
          state_next = ST_DN_RD;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        op         = OP_FINISH;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        op         = OP_EMIT;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/kwm_dpath.sv
// Datapath for the k-way merge selector: slot and key memories, the
// sifting registers, comparators and the result word. Depends on kwm_pkg.
module kwm_dpath import kwm_pkg::*; #(
  parameter int MAX_RUNS = MAX_RUNS_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  dp_op_t              op,
  input  logic [1:0]          cmd,
  input  logic [RUN_IN_W-1:0] run,
  input  logic [KEY_IN_W-1:0] key,
  output dp_status_t          status,
  output logic                done,
  output logic                valid_res,
  output logic [RUN_IN_W-1:0] winner_run,
  output logic [KEY_IN_W-1:0] winner_key,
  output logic [LIVE_W-1:0]   live_runs,
  output logic                error
);

  localparam int RW = $clog2(MAX_RUNS);
  localparam int CW = $clog2(MAX_RUNS + 1);
  localparam int PW = RW + 2;

  function automatic logic ahead_of(input logic [KEY_BITS-1:0] ka, input logic [RW-1:0] ra,
                                    input logic [KEY_BITS-1:0] kb, input logic [RW-1:0] rb);
    return (ka < kb) || ((ka == kb) && (ra < rb));
  endfunction

  // run index wrapped into the heap's range, worked out at elaboration
  logic [RW-1:0] run_wrap [RUN_CODES];
  for (genvar i = 0; i < RUN_CODES; i++) begin : g_wrap
    assign run_wrap[i] = RW'(i % MAX_RUNS);
  end

  logic [RW-1:0]       slots [MAX_RUNS];
  logic [KEY_BITS-1:0] keys  [MAX_RUNS];

  cmd_t                cmd_q;
  logic                err_q;
  logic [RW-1:0]       run_q;
  logic [KEY_BITS-1:0] key_q;
  logic [CW-1:0]       count;
  logic [RW-1:0]       pos;
  logic [RW-1:0]       mv_run;
  logic [KEY_BITS-1:0] mv_key;
  logic [RW-1:0]       top_run;
  logic [KEY_BITS-1:0] top_key;

  logic [RW-1:0]       s_rd_a, s_rd_b;
  logic [KEY_BITS-1:0] k_rd_a, k_rd_b;

  logic                s_we, s_re, k_we, k_re;
  logic [RW-1:0]       s_wa, s_wd, s_ra_a, s_ra_b;
  logic [RW-1:0]       k_wa, k_ra_a, k_ra_b;

  logic [PW-1:0]       child1, child2, count_x;
  logic [RW-1:0]       parent, last_idx;
  logic                has2, b_before_a, a_before_m, b_before_m;
  logic [RW-1:0]       best_run, best_idx;
  logic [KEY_BITS-1:0] best_key;
  logic                in_err;

  assign child1   = {1'b0, pos, 1'b1};
  assign child2   = child1 + PW'(1);
  assign count_x  = PW'(count);
  assign has2     = (child2 < count_x);
  assign parent   = (pos - RW'(1)) >> 1;
  assign last_idx = RW'(count - CW'(1));

  // both children tested against the mover in parallel with each other
  assign b_before_a = has2 && ahead_of(k_rd_b, s_rd_b, k_rd_a, s_rd_a);
  assign a_before_m = ahead_of(k_rd_a, s_rd_a, mv_key, mv_run);
  assign b_before_m = ahead_of(k_rd_b, s_rd_b, mv_key, mv_run);
  assign best_run   = b_before_a ? s_rd_b : s_rd_a;
  assign best_key   = b_before_a ? k_rd_b : k_rd_a;
  assign best_idx   = b_before_a ? RW'(child2) : RW'(child1);

  assign in_err = ((cmd_t'(cmd) == CMD_LOAD) && (count == CW'(MAX_RUNS))) ||
                  (((cmd_t'(cmd) == CMD_ADVANCE) || (cmd_t'(cmd) == CMD_EXHAUST)) &&
                   (count == '0));

  assign status.cmd     = cmd_q;
  assign status.err     = err_q;
  assign status.last    = (count == CW'(1));
  assign status.at_root = (pos == '0);
  assign status.up_go   = ahead_of(mv_key, mv_run, k_rd_a, s_rd_a);
  assign status.dn_leaf = (child1 >= count_x);
  assign status.dn_go   = b_before_a ? b_before_m : a_before_m;

  // memory port control
  always_comb begin
    s_we   = 1'b0;
    s_wa   = pos;
    s_wd   = mv_run;
    s_re   = 1'b0;
    s_ra_a = RW'(child1);
    s_ra_b = RW'(child2);
    k_we   = 1'b0;
    k_wa   = run_q;
    k_re   = 1'b0;
    k_ra_a = s_rd_a;
    k_ra_b = s_rd_b;
    unique case (op)
      OP_LOAD: begin
        k_we = 1'b1;
      end
      OP_ADVANCE: begin
        k_we = 1'b1;
        k_wa = top_run;
      end
      OP_EX_DEC: begin
        s_re   = 1'b1;
        s_ra_a = last_idx;
      end
      OP_UP_READ: begin
        s_re   = 1'b1;
        s_ra_a = parent;
      end
      OP_DN_READ: begin
        s_re = 1'b1;
      end
      OP_EX_KEY, OP_UP_KEY, OP_DN_KEY: begin
        k_re = 1'b1;
      end
      OP_UP_MOVE: begin
        s_we = 1'b1;
        s_wd = s_rd_a;
      end
      OP_DN_MOVE: begin
        s_we = 1'b1;
        s_wd = best_run;
      end
      OP_FINISH: begin
        s_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      slots[s_wa] <= s_wd;
    end
    if (s_re) begin
      s_rd_a <= slots[s_ra_a];
      s_rd_b <= slots[s_ra_b];
    end
  end

  always_ff @(posedge clk) begin
    if (k_we) begin
      keys[k_wa] <= key_q;
    end
    if (k_re) begin
      k_rd_a <= keys[k_ra_a];
      k_rd_b <= keys[k_ra_b];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= (op == OP_EMIT);
      if (op == OP_LOAD) begin
        count <= count + CW'(1);
      end else if (op == OP_EX_DEC) begin
        count <= count - CW'(1);
      end
    end
  end

  // sifting registers and the top-of-heap copy
  always_ff @(posedge clk) begin
    unique case (op)
      OP_TAKE: begin
        cmd_q <= cmd_t'(cmd);
        run_q <= run_wrap[run];
        key_q <= KEY_BITS'(key);
        err_q <= in_err;
      end
      OP_LOAD: begin
        mv_run <= run_q;
        mv_key <= key_q;
        pos    <= RW'(count);
        // reloading the run at the top changes the top key in place
        if ((count != '0) && (run_q == top_run)) begin
          top_key <= key_q;
        end
      end
      OP_ADVANCE: begin
        mv_run  <= top_run;
        mv_key  <= key_q;
        pos     <= '0;
        top_key <= key_q;
      end
      OP_EX_SET: begin
        mv_run <= s_rd_a;
        mv_key <= k_rd_a;
        pos    <= '0;
      end
      OP_UP_MOVE: begin
        pos <= parent;
      end
      OP_DN_MOVE: begin
        pos <= best_idx;
        if (pos == '0) begin
          top_run <= best_run;
          top_key <= best_key;
        end
      end
      OP_FINISH: begin
        if (pos == '0) begin
          top_run <= mv_run;
          top_key <= mv_key;
        end
      end
      default: begin
      end
    endcase
  end

  // result word
  always_ff @(posedge clk) begin
    if (op == OP_EMIT) begin
      valid_res  <= (count != '0);
      winner_run <= (count != '0) ? RUN_IN_W'(top_run) : '0;
      winner_key <= (count != '0) ? KEY_IN_W'(top_key) : '0;
      live_runs  <= LIVE_W'(count);
      error      <= err_q;
    end
  end

endmodule

### hdl/kway_merge_min_heap.sv
// A fault, an unused command or the last run leaving goes from decode to the result word;
// a load sifts up; an advance, or an exhaust after reading the last slot and key, sifts down.
// A sift passes L <= ceil(log2 MAX_RUNS) heap levels, each by slot read, key read, compare/move.
// One word is worked on at a time; busy falls in the cycle done is high, so start may follow.
// Synchronous active-high reset empties the heap; slot and key memories are not cleared.
// The receiver cannot stall: done is high for one cycle only and marks the result word.
`include "assert_macros.svh"

module kway_merge_min_heap import kwm_pkg::*; #(
  parameter int MAX_RUNS = MAX_RUNS_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          cmd,
  input  logic [RUN_IN_W-1:0] run,
  input  logic [KEY_IN_W-1:0] key,
  output logic                done,
  output logic                valid_res,
  output logic [RUN_IN_W-1:0] winner_run,
  output logic [KEY_IN_W-1:0] winner_key,
  output logic [LIVE_W-1:0]   live_runs,
  output logic                error
);

  dp_op_t     op;
  dp_status_t status;

  kwm_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .busy   (busy),
    .op     (op)
  );

  kwm_dpath #(
    .MAX_RUNS (MAX_RUNS),
    .KEY_BITS (KEY_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .cmd        (cmd),
    .run        (run),
    .key        (key),
    .status     (status),
    .done       (done),
    .valid_res  (valid_res),
    .winner_run (winner_run),
    .winner_key (winner_key),
    .live_runs  (live_runs),
    .error      (error)
  );

  `ASSERT_SAME_CYCLE(a_done_idle, clk, rst, done, !busy, "result word while still busy")
  `ASSERT_NEXT_CYCLE(a_take_busy, clk, rst, start && !busy, busy, "taken word did not raise busy")
  `ASSERT_SAME_CYCLE(a_empty_zero, clk, rst, done && !valid_res, (winner_run == '0) && (winner_key == '0), "empty heap reports a winner")
  `ASSERT_NEXT_CYCLE(a_emit_done, clk, rst, op == OP_EMIT, done, "emit without result strobe")

endmodule

### tb/sv/tb_kway_merge_min_heap.sv
// Self-checking bench for the k-way merge selector: directed table, then random merge phases.
// Typed wants or a heap predictor check every result word; needs kwm_pkg and the RTL top.
`timescale 1ns / 100ps

module tb_kway_merge_min_heap;
  import kwm_pkg::*;

  localparam int RAND_WORDS = 650;
  localparam int DIR_ROWS   = 20;
  localparam int DRAIN_WAIT = 30;
  localparam logic [KEY_IN_W-1:0] KEY_MAX = '1;

  typedef struct packed {
    logic                valid;
    logic [RUN_IN_W-1:0] wrun;
    logic [KEY_IN_W-1:0] wkey;
    logic [LIVE_W-1:0]   live;
    logic                err;
  } top_word_t;

  typedef struct packed {
    cmd_t                cmd;
    logic [RUN_IN_W-1:0] run;
    logic [KEY_IN_W-1:0] key;
    logic                typed;
    top_word_t           want;
  } dir_row_t;

  // want is typed in only where it is obvious; other rows go by the predictor
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{CMD_ADVANCE, 6'd0,  32'd0,        1'b1, '{1'b0, 6'd0,  32'd0,   7'd0, 1'b1}},
    '{CMD_EXHAUST, 6'd0,  32'd0,        1'b1, '{1'b0, 6'd0,  32'd0,   7'd0, 1'b1}},
    '{CMD_NONE,    6'd63, KEY_MAX,      1'b1, '{1'b0, 6'd0,  32'd0,   7'd0, 1'b0}},
    '{CMD_LOAD,    6'd63, KEY_MAX,      1'b1, '{1'b1, 6'd63, KEY_MAX, 7'd1, 1'b0}},
    '{CMD_LOAD,    6'd0,  KEY_MAX,      1'b1, '{1'b1, 6'd0,  KEY_MAX, 7'd2, 1'b0}},
    '{CMD_LOAD,    6'd21, 32'd0,        1'b1, '{1'b1, 6'd21, 32'd0,   7'd3, 1'b0}},
    '{CMD_LOAD,    6'd42, 32'd0,        1'b1, '{1'b1, 6'd21, 32'd0,   7'd4, 1'b0}},
    '{CMD_NONE,    6'd42, 32'd5,        1'b1, '{1'b1, 6'd21, 32'd0,   7'd4, 1'b0}},
    '{CMD_ADVANCE, 6'd0,  32'hAAAAAAAA, 1'b0, '0},
    '{CMD_ADVANCE, 6'd0,  32'h55555555, 1'b0, '0},
    '{CMD_LOAD,    6'd42, 32'd7,        1'b0, '0},
    '{CMD_LOAD,    6'd5,  32'd3,        1'b0, '0},
    '{CMD_ADVANCE, 6'd0,  KEY_MAX,      1'b0, '0},
    '{CMD_EXHAUST, 6'd0,  32'd0,        1'b0, '0},
    '{CMD_EXHAUST, 6'd0,  32'd0,        1'b0, '0},
    '{CMD_EXHAUST, 6'd0,  32'd0,        1'b0, '0},
    '{CMD_EXHAUST, 6'd0,  32'd0,        1'b0, '0},
    '{CMD_EXHAUST, 6'd0,  32'd0,        1'b0, '0},
    '{CMD_EXHAUST, 6'd0,  32'd0,        1'b1, '{1'b0, 6'd0,  32'd0,   7'd0, 1'b0}},
    '{CMD_EXHAUST, 6'd0,  32'd0,        1'b1, '{1'b0, 6'd0,  32'd0,   7'd0, 1'b1}}
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [1:0]          cmd = CMD_NONE;
  logic [RUN_IN_W-1:0] run = '0;
  logic [KEY_IN_W-1:0] key = '0;
  logic                busy;
  logic                done;
  logic                valid_res;
  logic [RUN_IN_W-1:0] winner_run;
  logic [KEY_IN_W-1:0] winner_key;
  logic [LIVE_W-1:0]   live_runs;
  logic                error;

  kway_merge_min_heap u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .run        (run),
    .key        (key),
    .done       (done),
    .valid_res  (valid_res),
    .winner_run (winner_run),
    .winner_key (winner_key),
    .live_runs  (live_runs),
    .error      (error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Heap predictor state
  logic [RUN_IN_W-1:0] heap_order [MAX_RUNS_DEF];
  logic [KEY_IN_W-1:0] run_key    [MAX_RUNS_DEF];
  int                  heap_fill;

  top_word_t want_q [$];
  int        mismatches;
  int        words_seen;
  bit        gaps_on;

  function automatic bit ranks_first(logic [RUN_IN_W-1:0] a, logic [RUN_IN_W-1:0] b);
    if (run_key[a] != run_key[b])
      return run_key[a] < run_key[b];
    return a < b;
  endfunction

  function automatic void bubble_up(int pos);
    int                  parent;
    logic [RUN_IN_W-1:0] t;
    while (pos > 0) begin
      parent = (pos - 1) / 2;
      if (!ranks_first(heap_order[pos], heap_order[parent]))
        break;
      t = heap_order[pos];
      heap_order[pos] = heap_order[parent];
      heap_order[parent] = t;
      pos = parent;
    end
  endfunction

  function automatic void bubble_down(int pos);
    int                  child;
    logic [RUN_IN_W-1:0] t;
    forever begin
      child = 2 * pos + 1;
      if (child >= heap_fill)
        break;
      if (child + 1 < heap_fill && ranks_first(heap_order[child + 1], heap_order[child]))
        child++;
      if (!ranks_first(heap_order[child], heap_order[pos]))
        break;
      t = heap_order[pos];
      heap_order[pos] = heap_order[child];
      heap_order[child] = t;
      pos = child;
    end
  endfunction

  function automatic top_word_t apply_word(cmd_t c, logic [RUN_IN_W-1:0] r,
                                           logic [KEY_IN_W-1:0] k);
    top_word_t res;
    res = '0;
    case (c)
      CMD_LOAD: begin
        if (heap_fill >= MAX_RUNS_DEF) begin
          res.err = 1'b1;
        end else begin
          run_key[r] = k;
          heap_order[heap_fill] = r;
          heap_fill++;
          bubble_up(heap_fill - 1);
        end
      end
      CMD_ADVANCE: begin
        if (heap_fill == 0) begin
          res.err = 1'b1;
        end else begin
          run_key[heap_order[0]] = k;
          bubble_down(0);
        end
      end
      CMD_EXHAUST: begin
        if (heap_fill == 0) begin
          res.err = 1'b1;
        end else begin
          heap_fill--;
          heap_order[0] = heap_order[heap_fill];
          bubble_down(0);
        end
      end
      default: ;
    endcase
    if (heap_fill > 0) begin
      res.valid = 1'b1;
      res.wrun  = heap_order[0];
      res.wkey  = run_key[heap_order[0]];
    end
    res.live = LIVE_W'(heap_fill);
    return res;
  endfunction

  function automatic bit holds_run(logic [RUN_IN_W-1:0] r);
    for (int i = 0; i < heap_fill; i++)
      if (heap_order[i] == r)
        return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [KEY_IN_W-1:0] pick_key();
    case ($urandom_range(9))
      0:       return '0;
      1:       return KEY_MAX;
      2, 3, 4: return KEY_IN_W'($urandom_range(15));  // dense keys for ties
      default: return KEY_IN_W'($urandom());
    endcase
  endfunction

  function automatic int pick_goal();
    int roll;
    roll = $urandom_range(99);
    if (roll < 65)
      return $urandom_range(1, 10);
    if (roll < 85)
      return $urandom_range(11, 40);
    return MAX_RUNS_DEF;
  endfunction

  // Present one word, hold it until taken, then log what it should produce
  task automatic send_word(cmd_t c, logic [RUN_IN_W-1:0] r, logic [KEY_IN_W-1:0] k,
                           bit typed, top_word_t want);
    top_word_t pred;
    if (gaps_on && $urandom_range(99) < 17) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    run   <= r;
    key   <= k;
    do @(posedge clk); while (busy);
    pred = apply_word(c, r, k);
    want_q.insert(want_q.size(), typed ? want : pred);
  endtask

  // Result checker: done marks a word for one cycle only
  always @(posedge clk) begin
    top_word_t got;
    top_word_t exp;
    if (!rst && done) begin
      got = '{valid_res, winner_run, winner_key, live_runs, error};
      words_seen++;
      if (want_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result word %0d arrived with nothing pending: valid=%0d run=%0d key=%h live=%0d err=%0d",
                   words_seen, got.valid, got.wrun, got.wkey, got.live, got.err);
      end else begin
        exp = want_q.pop_front();
        if (got.valid !== exp.valid || got.wrun !== exp.wrun || got.wkey !== exp.wkey ||
            got.live !== exp.live || got.err !== exp.err) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result word %0d wrong", words_seen);
            $display("  exp valid=%0d run=%0d key=%h live=%0d err=%0d",
                     exp.valid, exp.wrun, exp.wkey, exp.live, exp.err);
            $display("  got valid=%0d run=%0d key=%h live=%0d err=%0d",
                     got.valid, got.wrun, got.wkey, got.live, got.err);
          end
        end
      end
    end
  end

  initial begin
    int                  words_sent;
    int                  goal;
    int                  roll;
    bit                  filling;
    cmd_t                c;
    logic [RUN_IN_W-1:0] r;
    logic [KEY_IN_W-1:0] k;

    mismatches = 0;
    words_seen = 0;
    heap_fill  = 0;
    gaps_on    = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++)
      send_word(DIR_TABLE[i].cmd, DIR_TABLE[i].run, DIR_TABLE[i].key,
                DIR_TABLE[i].typed, DIR_TABLE[i].want);

    // Random merge phases: fill to a goal, then advance and exhaust until empty
    words_sent = 0;
    filling    = 1'b1;
    goal       = pick_goal();
    while (words_sent < RAND_WORDS) begin
      gaps_on = !(words_sent >= 200 && words_sent < 400);
      roll = $urandom_range(99);
      r = RUN_IN_W'($urandom_range(RUN_CODES - 1));
      k = pick_key();
      if (roll < 4) begin
        c = CMD_NONE;
      end else if (roll < 9) begin
        c = cmd_t'($urandom_range(2));  // stray word, may duplicate a run or fault
      end else if (filling) begin
        if (heap_fill < goal && heap_fill < MAX_RUNS_DEF) begin
          c = CMD_LOAD;
          while (holds_run(r))
            r = RUN_IN_W'($urandom_range(RUN_CODES - 1));
        end else if (heap_fill == MAX_RUNS_DEF && $urandom_range(2) == 0) begin
          c = CMD_LOAD;  // full heap
        end else begin
          filling = 1'b0;
          c = CMD_ADVANCE;
        end
      end else if (heap_fill == 0) begin
        if ($urandom_range(3) == 0) begin
          c = $urandom_range(1) ? CMD_ADVANCE : CMD_EXHAUST;
        end else begin
          filling = 1'b1;
          goal = pick_goal();
          c = CMD_LOAD;
        end
      end else begin
        c = ($urandom_range(99) < 55) ? CMD_ADVANCE : CMD_EXHAUST;
      end
      // merge-like advance: next head key near the current one
      if (c == CMD_ADVANCE && heap_fill > 0 && $urandom_range(1) == 0)
        k = run_key[heap_order[0]] + KEY_IN_W'($urandom_range(3));
      send_word(c, r, k, 1'b0, '0);
      if (c != CMD_NONE)
        words_sent++;
    end
    start <= 1'b0;

    while (want_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
